// ----- src/osm_pkg.sv -----
// Package: constants, command codes and shared types for the order-statistic multiset.
`default_nettype none
package osm_pkg;
  localparam int Capacity = 1024;
  localparam int AddrW = $clog2(Capacity);
  localparam int OccW = $clog2(Capacity + 1);
  localparam int ValW = 32;
  localparam int CntW = 16;
  localparam int SumW = 48;
  localparam logic [CntW-1:0] CntMax = '1;
  localparam logic [31:0] RankMax = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_RANK   = 3'd2,
    CMD_KTH    = 3'd3,
    CMD_PRED   = 3'd4,
    CMD_SUCC   = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [ValW-1:0] val;
    logic [CntW-1:0] cnt;
  } entry_t;
endpackage
`default_nettype wire

// ----- src/osm_ram.sv -----
// Single-port entry memory: one address per cycle, always read and written when we is high; read data registered.
`default_nettype none
module osm_ram (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [osm_pkg::AddrW-1:0] addr,
  input  wire osm_pkg::entry_t         wdata,
  output osm_pkg::entry_t              rdata
);
  import osm_pkg::*;
  entry_t mem [Capacity];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- src/order_statistic_multiset.sv -----
// Top level: sorted multiset kept in one entry memory, scanned and shifted by a sequencer.
//
//  channel | dir | words                       | handshake
//  s_axis  | in  | command, operand_value      | s_axis_tvalid / s_axis_tready
//  m_axis  | out | answer, found               | m_axis_tvalid / m_axis_tready
//
// Each command scans the memory from index 0, an S_RD and an S_CHK state per
// entry visited, until the search position; a new insert or a last-copy remove
// then shifts the tail one entry at a time via S_SHRD/S_SHWR. Cost grows with
// occupancy. Reset clears state, occupancy and m_axis_tvalid; the result
// register holds while m_axis_tready is low and no new word is taken meanwhile.
`default_nettype none
module order_statistic_multiset (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // [2:0] command, [34:3] operand_value, zero fill
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [31:0] answer
  output logic             m_axis_tuser   // [0] found
);
  import osm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_CHK   = 6'b000100,
    S_SHRD  = 6'b001000,
    S_SHWR  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  logic [2:0]      cmd;
  logic [ValW-1:0] x;
  logic [OccW-1:0] occ;
  logic [OccW-1:0] idx;
  logic [OccW-1:0] idx_prev;
  logic [SumW-1:0] sum;
  logic [ValW-1:0] prev;
  logic            have_prev;
  logic            hit_pend;
  entry_t          carry;
  logic            we;
  logic [AddrW-1:0] addr;
  entry_t          wdata;
  entry_t          rdata;

  osm_ram u_ram (.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  logic less, eq, atend;
  logic [SumW-1:0] sum_add;
  assign less    = (rdata.val ^ 32'h8000_0000) < (x ^ 32'h8000_0000);
  assign eq      = rdata.val == x;
  assign atend   = idx == occ;
  assign sum_add = sum + SumW'(rdata.cnt);
  assign idx_prev = idx - 1'b1;

  assign s_axis_tready = state == S_IDLE;

  // memory port: carry written at idx in S_SHWR; remove shift: entry read at idx goes down to idx-1
  always_comb begin
    we    = 1'b0;
    addr  = idx[AddrW-1:0];
    wdata = carry;
    if (state == S_SHWR) begin
      we = 1'b1;
      if (cmd == CMD_REMOVE && hit_pend) begin
        addr  = idx_prev[AddrW-1:0];
        wdata = rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      occ           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd       <= s_axis_tdata[2:0];
            x         <= s_axis_tdata[34:3];
            idx       <= '0;
            sum       <= '0;
            have_prev <= 1'b0;
            hit_pend  <= 1'b0;
            state     <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          priority if (cmd == CMD_KTH) begin
            if (x == '0 || x[31] || atend) begin
              m_axis_tdata <= '0; m_axis_tuser <= 1'b0; state <= S_OUT;
            end else if (sum_add >= SumW'(x)) begin
              m_axis_tdata <= rdata.val; m_axis_tuser <= 1'b1; state <= S_OUT;
            end else begin
              sum <= sum_add; idx <= idx + 1'b1; state <= S_RD;
            end
          end else if (cmd == CMD_SUCC && hit_pend) begin
            m_axis_tdata <= atend ? '0 : rdata.val;
            m_axis_tuser <= !atend;
            state <= S_OUT;
          end else if (!atend && less) begin
            sum <= sum_add; prev <= rdata.val; have_prev <= 1'b1;
            idx <= idx + 1'b1; state <= S_RD;
          end else begin
            unique case (cmd)
              CMD_RANK: begin
                m_axis_tdata <= (sum + 1'b1 > SumW'(RankMax)) ? RankMax : sum[31:0] + 1'b1;
                m_axis_tuser <= 1'b1; state <= S_OUT;
              end
              CMD_PRED: begin
                m_axis_tdata <= have_prev ? prev : '0;
                m_axis_tuser <= have_prev; state <= S_OUT;
              end
              CMD_SUCC: begin
                if (!atend && eq) begin
                  hit_pend <= 1'b1; idx <= idx + 1'b1; state <= S_RD;
                end else begin
                  m_axis_tdata <= atend ? '0 : rdata.val;
                  m_axis_tuser <= !atend; state <= S_OUT;
                end
              end
              CMD_INSERT: begin
                if (!atend && eq) begin
                  carry <= '{val: rdata.val,
                             cnt: (rdata.cnt == CntMax) ? CntMax : rdata.cnt + 1'b1};
                  hit_pend <= 1'b0; state <= S_SHWR;
                end else if (occ == OccW'(Capacity)) begin
                  state <= S_IDLE;
                end else begin
                  carry <= '{val: x, cnt: CntW'(1)};
                  hit_pend <= 1'b1; occ <= occ + 1'b1; state <= S_SHWR;
                end
              end
              CMD_REMOVE: begin
                if (!atend && eq) begin
                  if (rdata.cnt > CntW'(1)) begin
                    carry <= '{val: rdata.val, cnt: rdata.cnt - 1'b1};
                    hit_pend <= 1'b0; state <= S_SHWR;
                  end else if (idx + 1'b1 == occ) begin
                    occ <= occ - 1'b1; state <= S_IDLE;
                  end else begin
                    idx <= idx + 1'b1; hit_pend <= 1'b1; occ <= occ - 1'b1;
                    state <= S_SHRD;
                  end
                end else begin
                  state <= S_IDLE;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SHRD: begin
          state <= S_SHWR;
        end
        S_SHWR: begin
          if (cmd == CMD_INSERT) begin
            // write carry at idx, pick up old entry for next slot
            carry <= rdata;
            idx   <= idx + 1'b1;
            if (!hit_pend || idx + 1'b1 == occ) begin
              state <= S_IDLE;
            end else begin
              state <= S_SHRD;
            end
          end else begin
            if (!hit_pend || idx == occ) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_SHRD;
            end
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- src/osm_checker.sv -----
// Port checker for the order-statistic multiset, bound to the top level.
`default_nettype none
module osm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");
  a_take: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after accept");
  a_nf: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("missing answer not zero");
endmodule

bind order_statistic_multiset osm_checker u_osm_checker (.*);
`default_nettype wire
